>>> rtl/fpa_pkg.sv
// Shared types, codes and helpers for the fixed-point ALU.
// No dependencies; every other rtl file except fpa_ifs imports this package.
`default_nettype none
package fpa_pkg;

  // Operation codes carried in a request
  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;
  localparam logic [2:0] MODE_REM = 3'd4;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_DIVZ  = 2'd1;
  localparam logic [1:0] STAT_UNSUP = 2'd2;

  // Width select codes
  localparam logic [1:0] WSEL_8  = 2'd0;
  localparam logic [1:0] WSEL_16 = 2'd1;
  localparam logic [1:0] WSEL_32 = 2'd2;
  localparam logic [1:0] WSEL_64 = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_WSEL = 2'd0;
  localparam logic [1:0] CFG_SGN  = 2'd1;
  localparam logic [1:0] CFG_FRAC = 2'd2;

  // Work kinds handed from the front end to the back end
  localparam logic [1:0] KIND_DONE = 2'd0;
  localparam logic [1:0] KIND_MUL  = 2'd1;
  localparam logic [1:0] KIND_DIV  = 2'd2;
  localparam logic [1:0] KIND_REM  = 2'd3;

  typedef struct packed {
    logic [1:0]        wsel;
    logic              is_signed;
    logic signed [7:0] frac;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        status;
    logic [63:0]       res;      // final result for KIND_DONE
    logic [31:0]       lhs_mag;
    logic [31:0]       rhs_mag;
    logic              neg;      // sign to apply to the magnitude
    logic signed [7:0] frac;
    logic [1:0]        wsel;
  } op_t;

  function automatic logic [63:0] wmask(input logic [1:0] wsel);
    logic [63:0] m;
    m = '1;
    case (wsel)
      WSEL_8:  m = 64'h0000_0000_0000_00FF;
      WSEL_16: m = 64'h0000_0000_0000_FFFF;
      WSEL_32: m = 64'h0000_0000_FFFF_FFFF;
      default: m = '1;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

>>> rtl/fpa_ifs.sv
// Valid/ready channel interfaces for requests and results.
// Depends on nothing.
`default_nettype none
interface fpa_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [63:0] lhs_raw;
  logic [63:0] rhs_raw;
  modport source (output valid, mode, lhs_raw, rhs_raw, input ready);
  modport sink   (input valid, mode, lhs_raw, rhs_raw, output ready);
endinterface

interface fpa_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_raw;
  logic [1:0]  status;
  modport source (output valid, result_raw, status, input ready);
  modport sink   (input valid, result_raw, status, output ready);
endinterface
`default_nettype wire

>>> rtl/fixed_point_alu.sv
// Top level of the fixed-point ALU: configuration registers, front end,
// request queue and back end. Depends on fpa_pkg, fpa_ifs and submodules.
//
// Usage:
//  - in_ch carries requests (mode, lhs_raw, rhs_raw); a request is taken on
//    a clock edge with valid and ready high. out_ch returns one result
//    (result_raw, status) per request, in order, under the same handshake.
//  - cfg_we/cfg_index/cfg_wdata write width_select (0), is_signed (1) and
//    the fractional bit count (2, signed). Write only while no request is
//    in flight.
//  - Add, subtract and error cases pass from the queue to the output
//    register; multiply goes through the product register, then the
//    scaling shift; divide and remainder go through the restoring divider,
//    one bit per cycle; divide adds a step per fraction bit if positive.
//  - Throughput: add/subtract/error requests stream at one per cycle while
//    the back end is idle and the receiver takes results; multiply, divide
//    and remainder hold the back end until their result is loaded.
//  - The two-entry queue lets the front keep taking requests while the
//    back end works or the receiver stalls; a stalled result sits in the
//    output register and ready drops once the queue fills.
//  - Reset (rst_n low, synchronous) empties the queue, drops out valid and
//    loads width 32 bits, signed, 16 fractional bits.
`default_nettype none
module fixed_point_alu (
  input  logic       clk,
  input  logic       rst_n,
  fpa_in_if.sink     in_ch,
  fpa_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);
  import fpa_pkg::*;

  cfg_t cfg_r;
  logic q_full, push, pop, q_valid;
  op_t  push_op, q_op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wsel      <= WSEL_32;
      cfg_r.is_signed <= 1'b1;
      cfg_r.frac      <= 8'sd16;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WSEL: cfg_r.wsel      <= cfg_wdata[1:0];
        CFG_SGN:  cfg_r.is_signed <= cfg_wdata[0];
        CFG_FRAC: cfg_r.frac      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  fpa_front u_front (
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_full (q_full),
    .push   (push),
    .op     (push_op)
  );

  fpa_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .full    (q_full),
    .q_valid (q_valid),
    .q_op    (q_op)
  );

  fpa_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_op    (q_op),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

>>> rtl/fpa_front.sv
// Front end: accepts requests, finishes add/sub and errors, splits operands.
// Depends on fpa_pkg and fpa_in_if.
`default_nettype none
module fpa_front (
  fpa_in_if.sink        in_ch,
  input  fpa_pkg::cfg_t cfg,
  input  logic          q_full,
  output logic          push,
  output fpa_pkg::op_t  op
);
  import fpa_pkg::*;

  logic [63:0] m, lv, rv;
  logic        ls, rs, nl, nr;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    m  = wmask(cfg.wsel);
    lv = in_ch.lhs_raw & m;
    rv = in_ch.rhs_raw & m;
    case (cfg.wsel)
      WSEL_8:  begin ls = lv[7];  rs = rv[7];  end
      WSEL_16: begin ls = lv[15]; rs = rv[15]; end
      default: begin ls = lv[31]; rs = rv[31]; end
    endcase
    nl = cfg.is_signed && ls;
    nr = cfg.is_signed && rs;

    op.kind    = KIND_DONE;
    op.status  = STAT_OK;
    op.res     = '0;
    op.lhs_mag = nl ? 32'(~lv + 64'd1) & m[31:0] : lv[31:0];
    op.rhs_mag = nr ? 32'(~rv + 64'd1) & m[31:0] : rv[31:0];
    op.neg     = nl ^ nr;
    op.frac    = cfg.frac;
    op.wsel    = cfg.wsel;

    unique case (in_ch.mode) inside
      MODE_ADD: op.res = (in_ch.lhs_raw + in_ch.rhs_raw) & m;
      MODE_SUB: op.res = (in_ch.lhs_raw - in_ch.rhs_raw) & m;
      MODE_MUL, MODE_DIV, MODE_REM: begin
        if (cfg.wsel == WSEL_64) begin
          op.status = STAT_UNSUP;
        end else if (in_ch.mode == MODE_MUL) begin
          op.kind = KIND_MUL;
        end else if (op.rhs_mag == '0) begin
          op.status = STAT_DIVZ;
        end else if (in_ch.mode == MODE_DIV) begin
          op.kind = KIND_DIV;
        end else begin
          op.kind = KIND_REM;
          op.neg  = nl;   // remainder takes the dividend's sign
        end
      end
      default: op.status = STAT_UNSUP;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/fpa_queue.sv
// Two-entry request queue between front and back ends.
// Depends on fpa_pkg.
`default_nettype none
module fpa_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  fpa_pkg::op_t push_op,
  input  logic         pop,
  output logic         full,
  output logic         q_valid,
  output fpa_pkg::op_t q_op
);
  import fpa_pkg::*;

  op_t        mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = cnt_r == 2'd2;
  assign q_valid = cnt_r != 2'd0;
  assign q_op    = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_op;
  end

endmodule
`default_nettype wire

>>> rtl/fpa_back.sv
// Back end: multiplier, bit-serial divider and the result register.
// Depends on fpa_pkg and fpa_out_if.
`default_nettype none
module fpa_back (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  fpa_pkg::op_t q_op,
  output logic         pop,
  fpa_out_if.source    out_ch
);
  import fpa_pkg::*;

  localparam logic [1:0] S_RUN = 2'd0;
  localparam logic [1:0] S_MUL = 2'd1;
  localparam logic [1:0] S_DIV = 2'd2;

  logic [1:0]  st_r, st_nxt;
  op_t         cur_r;
  logic [63:0] prod_r;
  logic [31:0] a_r, rem_r, quo_r;
  logic [7:0]  cnt_r;
  logic        out_valid_r;
  logic [63:0] out_res_r;
  logic [1:0]  out_stat_r;

  logic        out_free, ld_out;
  logic [63:0] fin_mag, fin_val;
  logic        fin_neg;
  logic [1:0]  fin_stat, fin_wsel;
  logic [7:0]  k_u, n_init;
  logic [32:0] rem_sh;
  logic        ge;

  assign out_free          = !out_valid_r || out_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.result_raw = out_res_r;
  assign out_ch.status     = out_stat_r;

  // magnitude of a negative shift count (128 fits in 8 unsigned bits)
  assign k_u    = ~cur_r.frac + 8'd1;
  // remainder needs only the 32 dividend bits; divide adds a non-negative fraction shift
  assign n_init = 8'd32 + ((q_op.kind == KIND_DIV && q_op.frac[7] == 1'b0) ?
                           8'(q_op.frac) : 8'd0);
  assign rem_sh = {rem_r, a_r[31]};
  assign ge     = rem_sh >= {1'b0, cur_r.rhs_mag};

  always_comb begin
    st_nxt   = st_r;
    pop      = 1'b0;
    ld_out   = 1'b0;
    fin_mag  = '0;
    fin_neg  = 1'b0;
    fin_stat = STAT_OK;
    fin_wsel = cur_r.wsel;
    unique case (st_r)
      S_RUN: begin
        if (q_valid) begin
          case (q_op.kind)
            KIND_DONE: begin
              if (out_free) begin
                pop      = 1'b1;
                ld_out   = 1'b1;
                fin_mag  = q_op.res;
                fin_stat = q_op.status;
                fin_wsel = q_op.wsel;
              end
            end
            KIND_MUL: begin
              pop    = 1'b1;
              st_nxt = S_MUL;
            end
            default: begin
              pop    = 1'b1;
              st_nxt = S_DIV;
            end
          endcase
        end
      end
      S_MUL: begin
        if (out_free) begin
          ld_out  = 1'b1;
          fin_neg = cur_r.neg;
          st_nxt  = S_RUN;
          if (cur_r.frac[7]) begin
            fin_mag = (k_u >= 8'd64) ? '0 : prod_r << k_u[5:0];
          end else begin
            fin_mag = (cur_r.frac >= 8'sd64) ? '0 : prod_r >> cur_r.frac[5:0];
          end
        end
      end
      S_DIV: begin
        if (cnt_r == 8'd0 && out_free) begin
          ld_out  = 1'b1;
          fin_neg = cur_r.neg;
          st_nxt  = S_RUN;
          if (cur_r.kind == KIND_REM) begin
            fin_mag = {32'd0, rem_r};
          end else if (cur_r.frac[7]) begin
            fin_mag = (k_u >= 8'd32) ? '0 : {32'd0, quo_r >> k_u[4:0]};
          end else begin
            fin_mag = {32'd0, quo_r};
          end
        end
      end
      default: st_nxt = S_RUN;
    endcase
    fin_val = (fin_neg ? (64'd0 - fin_mag) : fin_mag) & wmask(fin_wsel);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_RUN;
      out_valid_r <= 1'b0;
      cnt_r       <= 8'd0;
    end else begin
      st_r <= st_nxt;
      if (ld_out) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (pop) cnt_r <= n_init;
      else if (st_r == S_DIV && cnt_r != 8'd0) cnt_r <= cnt_r - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_res_r  <= fin_val;
      out_stat_r <= fin_stat;
    end
    if (pop) begin
      cur_r  <= q_op;
      prod_r <= 64'(q_op.lhs_mag) * 64'(q_op.rhs_mag);
      a_r    <= q_op.lhs_mag;
      rem_r  <= '0;
      quo_r  <= '0;
    end else if (st_r == S_DIV && cnt_r != 8'd0) begin
      // one restoring step: shift in the next dividend bit (zeros after 32)
      rem_r <= ge ? 32'(rem_sh - {1'b0, cur_r.rhs_mag}) : rem_sh[31:0];
      quo_r <= {quo_r[30:0], ge};
      a_r   <= {a_r[30:0], 1'b0};
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stat_r != STAT_OK |-> out_res_r == '0)
    else $error("error result not zero");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_RUN |-> !pop)
    else $error("queue popped while unit busy");
  a_div_stays: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_DIV && cnt_r != 8'd0 |=> st_r == S_DIV)
    else $error("divide left before finishing");

endmodule
`default_nettype wire

>>> sim/tb_scoreboard.sv
// Scoreboard for the fixed-point ALU testbench: predicts each request's result.
// Depends on fpa_pkg for codes and widths.
`timescale 1ns / 100ps
import fpa_pkg::*;

class alu_scoreboard;
  logic [1:0]        wsel;
  logic              sgn;
  logic signed [7:0] frac;
  logic [63:0]       exp_res[$];
  logic [1:0]        exp_stat[$];
  int                mismatches;

  function new();
    wsel = WSEL_32;
    sgn = 1'b1;
    frac = 8'sd16;
    mismatches = 0;
  endfunction

  // sign/magnitude split at the active width
  function logic [63:0] mag_of(input logic [63:0] raw, input int bits, output logic neg);
    logic [63:0] m;
    logic [63:0] v;
    m = wmask(wsel);
    v = raw & m;
    neg = sgn && v[bits-1];
    return neg ? ((64'd0 - v) & m) : v;
  endfunction

  function void note_request(input logic [2:0] mode, input logic [63:0] a,
                             input logic [63:0] b);
    int bits;
    int k;
    logic [63:0] m, ml, mr, mag, res;
    logic [127:0] wide;
    logic nl, nr, neg;
    logic [1:0] st;
    bits = 8 << wsel;
    m = wmask(wsel);
    res = '0;
    st = STAT_OK;
    mag = '0;
    if (mode == MODE_ADD) res = (a + b) & m;
    else if (mode == MODE_SUB) res = (a - b) & m;
    else if (mode > MODE_REM || bits > 32) st = STAT_UNSUP;
    else begin
      ml = mag_of(a, bits, nl);
      mr = mag_of(b, bits, nr);
      neg = nl != nr;
      if (mode == MODE_MUL) begin
        mag = ml * mr;
        if (frac > 0) mag = (frac >= 64) ? '0 : mag >> frac;
        else if (frac < 0) begin
          k = -frac;
          mag = (k >= 64) ? '0 : mag << k;
        end
      end else if (mr == 0) st = STAT_DIVZ;
      else if (mode == MODE_DIV) begin
        if (frac >= 0) begin
          wide = {64'd0, ml} << frac;  // ml < 2^32, so a shift of up to 96 fits in 128 bits
          mag = (frac > 96) ? shifted_div(ml, mr, frac) : 64'(wide / mr);
        end else begin
          k = -frac;
          mag = ml / mr;
          mag = (k >= 64) ? '0 : mag >> k;
        end
      end else begin
        mag = ml % mr;
        neg = nl;
      end
      if (st == STAT_OK) res = (neg ? (64'd0 - mag) : mag) & m;
    end
    exp_res = {exp_res, res};
    exp_stat = {exp_stat, st};
  endfunction

  // long division for shifts past what a 128-bit dividend holds
  function logic [63:0] shifted_div(input logic [63:0] a, input logic [63:0] d, input int s);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 0; i < 32 + s; i++) begin
      r = {r[63:0], (i < 32) ? a[31-i] : 1'b0};
      q = q << 1;
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function void check_result(input logic [63:0] res, input logic [1:0] st);
    logic [63:0] er;
    logic [1:0] es;
    if (exp_res.size() == 0) begin
      fail_note("unexpected result", 0, res, 0, st);
      return;
    end
    er = exp_res.pop_front();
    es = exp_stat.pop_front();
    if (er !== res || es !== st) fail_note("mismatch", er, res, es, st);
  endfunction

  function void fail_note(input string what, input logic [63:0] er, input logic [63:0] ar,
                          input logic [1:0] es, input logic [1:0] as);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: exp res=%h st=%0d got res=%h st=%0d", what, er, es, ar, as);
  endfunction
endclass

>>> sim/tb_top.sv
// Top of the fixed-point ALU testbench: clock, reset, drivers and checks.
// Depends on fpa_pkg, fpa_ifs, fixed_point_alu and tb_scoreboard.
`timescale 1ns / 100ps
import fpa_pkg::*;

module tb_top;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_WSEL;
  logic [7:0] cfg_wdata = '0;

  fpa_in_if  in_ch();
  fpa_out_if out_ch();

  fixed_point_alu u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  alu_scoreboard sb = new();
  int idle_cycles = 0;
  bit stall_long = 1'b0;   // receiver hold-off requested by the stimulus
  bit timed_out = 1'b0;
  localparam int WATCHDOG = 20000;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_ADD;
    in_ch.lhs_raw = '0;
    in_ch.rhs_raw = '0;
    out_ch.ready = 1'b0;
  end

  // watchdog: cycles with no request and no result moving
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG && !timed_out) begin
      timed_out <= 1'b1;
      $display("[fixed_point_alu] ERROR");
      $finish;
    end
  end

  // result side: random gaps in ready, plus one long hold-off on request
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      if (stall_long) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        stall_long = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      sb.check_result(out_ch.result_raw, out_ch.status);
    end
  end

  task automatic write_cfg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WSEL) sb.wsel = val[1:0];
    else if (idx == CFG_SGN) sb.sgn = val[0];
    else sb.frac = val;
    @(posedge clk);
  endtask

  // wait for every expected result, then the slowest latency, then reconfigure
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.exp_res.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic send(input logic [2:0] mode, input logic [63:0] a, input logic [63:0] b,
                      input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.lhs_raw <= a;
    in_ch.rhs_raw <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(mode, a, b);
  endtask

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      2: v = 64'h8000_0000_0000_0000 >> (8 * $urandom_range(0, 7));  // sign-ish bits
      3: v = 64'($urandom_range(0, 7));
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // small fraction counts keep the serial divider quick; extremes now and then
  function automatic logic [7:0] rand_frac();
    case ($urandom_range(0, 9))
      0: return 8'sd64;
      1: return -8'sd32;
      2: return 8'h80;
      3: return 8'sd127;
      default: return 8'($signed($urandom_range(0, 24)) - 8);
    endcase
  endfunction

  initial begin
    logic [2:0] md;
    bit gaps;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset config, extremes, every mode, divide by zero, unknown modes
    send(MODE_ADD, '1, 64'd1, 1'b0);
    send(MODE_SUB, '0, 64'd1, 1'b0);
    send(MODE_MUL, 64'hFFFF_FFFF, 64'h8000_0000, 1'b0);
    send(MODE_MUL, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 1'b0);
    send(MODE_DIV, 64'h8000_0000, 64'hFFFF_FFFF, 1'b0);
    send(MODE_DIV, 64'd5, 64'd0, 1'b0);
    send(MODE_REM, 64'hFFFF_FFF9, 64'd2, 1'b0);
    send(MODE_REM, 64'd9, 64'h1_0000_0000, 1'b0);  // zero divisor in low bits
    send(3'd5, 64'd1, 64'd1, 1'b0);
    send(3'd7, '1, '1, 1'b0);
    drain();
    write_cfg(CFG_WSEL, {6'd0, WSEL_64});
    send(MODE_ADD, '1, '1, 1'b0);
    send(MODE_MUL, 64'd3, 64'd3, 1'b0);
    send(MODE_DIV, 64'd3, 64'd0, 1'b0);            // unsupported wins over zero divisor
    send(MODE_REM, 64'd3, 64'd1, 1'b0);
    drain();
    write_cfg(CFG_WSEL, {6'd0, WSEL_8});
    write_cfg(CFG_SGN, 8'd0);
    write_cfg(CFG_FRAC, -8'sd32);
    send(MODE_MUL, 64'hFF, 64'hFF, 1'b0);
    send(MODE_DIV, 64'hFF, 64'd1, 1'b0);
    drain();
    write_cfg(CFG_FRAC, 8'sd127);
    send(MODE_DIV, 64'hFF, 64'd3, 1'b0);
    send(MODE_MUL, 64'hFF, 64'hFF, 1'b0);
    drain();
    write_cfg(CFG_FRAC, 8'h80);
    send(MODE_DIV, 64'hFF, 64'd1, 1'b0);
    send(MODE_MUL, 64'h80, 64'h7F, 1'b0);
    drain();

    // random phases, a fresh config each; one phase holds the receiver off
    for (int ph = 0; ph < 30; ph++) begin
      write_cfg(CFG_WSEL, 8'($urandom_range(0, 3)));
      write_cfg(CFG_SGN, 8'($urandom_range(0, 1)));
      write_cfg(CFG_FRAC, rand_frac());
      if (ph == 3) stall_long = 1'b1;
      gaps = (ph % 4) != 1;
      for (int i = 0; i < 50; i++) begin
        md = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
        send(md, rand64(), ($urandom_range(0, 15) == 0) ? 64'd0 : rand64(), gaps);
      end
      in_ch.valid <= 1'b0;
      @(posedge clk);
      drain();
    end

    if (sb.mismatches == 0 && sb.exp_res.size() == 0) begin
      $display("[fixed_point_alu] OK");
    end else begin
      $display("[fixed_point_alu] ERROR");
    end
    $finish;
  end
endmodule
